[rtl/phte_pkg.sv]
`timescale 1ns / 1ps

package phte_pkg;

  // Payload widths
  localparam int COORD_W = 32;
  localparam int PT_W    = 3 * COORD_W;
  localparam int ACT_W   = 2;
  localparam int HB_W    = 32;
  localparam int TANG_W  = 18;
  localparam int STAT_W  = 2;

  // Parameter defaults
  localparam int MAX_POINTS_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DROP = 2'd3;

  localparam logic [TANG_W-1:0] TANG_MAX = '1;

endpackage

[rtl/phte_if.sv]
`timescale 1ns / 1ps

interface phte_cmd_if;
  import phte_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [ACT_W-1:0]           action;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;
  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

interface phte_rsp_if;
  import phte_pkg::*;
  logic               valid;
  logic               ready;
  logic [HB_W-1:0]    dist_bound;
  logic [TANG_W-1:0]  tan_err;
  logic [STAT_W-1:0]  status;
  modport source (output valid, dist_bound, tan_err, status, input ready);
  modport sink   (input valid, dist_bound, tan_err, status, output ready);
endinterface

[rtl/polyline_hausdorff_tangent_error_unit.sv]
`timescale 1ns / 1ps

// Hausdorff distance and tangent error of two closed 3D polylines.
// cmd channel (valid/ready): one transaction per command. Clear and point
// loads produce no result; a load into a full set is dropped and flagged.
// A compute transaction produces one rsp transaction with the bound, the
// tangent error and a status code.
// Compute visits every point-segment pair in both directions (nA*nB pairs
// each), clamping the projection or dividing for it, then takes the
// tangent error over the min(nA,nB) tangent edges. It uses the shared 34x17
// multiplier, which forms each product from half products, the one-bit-per-
// cycle divider and square root unit, and one read port per point memory.
// cmd.ready is high only while no compute runs; loads stream at one per
// cycle. The result sits in an output register; a stalled receiver holds
// it, and the next commands are still taken, but a following compute waits
// at its end until the register is free.
// Reset clears the counts, the dropped-load flag and the output valid; the
// point memories are not cleared and need no clearing pass.
module polyline_hausdorff_tangent_error_unit #(
  parameter int MAX_POINTS = phte_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = phte_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  phte_cmd_if.sink        cmd,
  phte_rsp_if.source      rsp
);
  import phte_pkg::*;

  localparam int IW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int DW   = COORD_W + 1;
  localparam int EW   = DW + 1;
  localparam int MW   = EW;
  localparam int MH   = MW / 2;
  localparam int PRW  = 2 * MW;
  localparam int AW   = PRW;
  localparam int N2W  = 2 * DW;
  localparam int SQW  = N2W + 2 * FRAC_BITS;
  localparam int RTW  = SQW / 2;
  localparam int SCW  = $clog2(RTW + 1);
  localparam int DVW  = AW;
  localparam int QW   = FRAC_BITS + 1;
  localparam int DCW  = $clog2(FRAC_BITS + 1);
  localparam int UW   = FRAC_BITS + 2;
  localparam int TDW  = FRAC_BITS + 3;
  localparam int TW   = (TDW > TANG_W) ? TDW : TANG_W;
  localparam logic [CW-1:0]  FULL  = CW'(MAX_POINTS);
  localparam logic [PRW-1:0] HALF  = PRW'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0]  T_ONE = QW'(1) << FRAC_BITS;
  localparam logic [TW-1:0]  TCAP  = TW'(1) << (FRAC_BITS + 1);

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_START  = 6'd1;
  localparam logic [5:0] S_H_RDP  = 6'd2;
  localparam logic [5:0] S_H_CAP0 = 6'd3;
  localparam logic [5:0] S_H_RDB  = 6'd4;
  localparam logic [5:0] S_H_CAPB = 6'd5;
  localparam logic [5:0] S_SEG0   = 6'd6;
  localparam logic [5:0] S_SEG1   = 6'd7;
  localparam logic [5:0] S_SEG2   = 6'd8;
  localparam logic [5:0] S_SEG3   = 6'd9;
  localparam logic [5:0] S_SEG4   = 6'd10;
  localparam logic [5:0] S_SEG4B  = 6'd11;
  localparam logic [5:0] S_SEG5   = 6'd12;
  localparam logic [5:0] S_SEG6   = 6'd13;
  localparam logic [5:0] S_SEG7   = 6'd14;
  localparam logic [5:0] S_SEG8   = 6'd15;
  localparam logic [5:0] S_H_NEXT = 6'd16;
  localparam logic [5:0] S_H_SQ   = 6'd17;
  localparam logic [5:0] S_H_DONE = 6'd18;
  localparam logic [5:0] S_T_RD0  = 6'd19;
  localparam logic [5:0] S_T_CAP0 = 6'd20;
  localparam logic [5:0] S_T_RD1  = 6'd21;
  localparam logic [5:0] S_T_CAP1 = 6'd22;
  localparam logic [5:0] S_UE1    = 6'd23;
  localparam logic [5:0] S_UE2    = 6'd24;
  localparam logic [5:0] S_UE3    = 6'd25;
  localparam logic [5:0] S_UE4    = 6'd26;
  localparam logic [5:0] S_UE5    = 6'd27;
  localparam logic [5:0] S_UE6    = 6'd28;
  localparam logic [5:0] S_UE_END = 6'd29;
  localparam logic [5:0] S_T_D1   = 6'd30;
  localparam logic [5:0] S_T_D2   = 6'd31;
  localparam logic [5:0] S_T_D3   = 6'd32;
  localparam logic [5:0] S_T_D4   = 6'd33;
  localparam logic [5:0] S_MUL    = 6'd34;
  localparam logic [5:0] S_DIV    = 6'd35;
  localparam logic [5:0] S_SQ     = 6'd36;
  localparam logic [5:0] S_FIN    = 6'd37;

  function automatic logic signed [COORD_W-1:0] coord(input logic [PT_W-1:0] w,
                                                      input logic [1:0] k);
    logic signed [COORD_W-1:0] c;
    case (k)
      2'd0:    c = w[PT_W-1 -: COORD_W];
      2'd1:    c = w[2*COORD_W-1 -: COORD_W];
      default: c = w[COORD_W-1:0];
    endcase
    return c;
  endfunction

  function automatic logic signed [DW-1:0] csub(input logic signed [COORD_W-1:0] x,
                                                input logic signed [COORD_W-1:0] y);
    return DW'(x) - DW'(y);
  endfunction

  function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] v);
    return v[EW-1] ? EW'(-v) : EW'(v);
  endfunction

  // Point memories
  logic [PT_W-1:0] mem_f [MAX_POINTS];
  logic [PT_W-1:0] mem_s [MAX_POINTS];
  logic [PT_W-1:0] rd_f, rd_s;
  logic [IW-1:0]   raddr_f, raddr_s;
  logic [PT_W-1:0] wword;
  logic            we_f, we_s, cmd_acc;

  logic [5:0]      state, ret;
  logic [CW-1:0]   fcnt, scnt;
  logic            ovf;
  logic [CW-1:0]   i_idx, j_idx;
  logic            dir, side, few;
  logic [1:0]      k;
  logic [PT_W-1:0] p_pt, a_pt, b_pt, z_pt;
  logic signed [DW-1:0] dv [3];
  logic signed [DW-1:0] av [3];
  logic [AW-1:0]   ab2, pos, neg, d2, best, worst;
  logic [QW-1:0]   t;
  logic [RTW-1:0]  len;
  logic signed [UW-1:0] u0 [3];
  logic signed [UW-1:0] u1 [3];
  logic [MW-1:0]   ma, mb;
  logic            mph;
  logic [PRW-1:0]  prod;
  logic [DVW-1:0]  dv_rem, dv_den;
  logic [QW-1:0]   quo;
  logic [DCW-1:0]  dcnt;
  logic [SQW-1:0]  sq_rad;
  logic [RTW-1:0]  root;
  logic [RTW:0]    srem;
  logic [SCW-1:0]  sq_cnt;
  logic [HB_W-1:0] hb;
  logic            hsat;
  logic [TW-1:0]   tworst;
  logic            o_valid;
  logic [HB_W-1:0] o_hb;
  logic [TANG_W-1:0] o_te;
  logic [STAT_W-1:0] o_st;

  // Loop bounds and wrap addresses
  logic [CW-1:0] nf, nt, tn, i_nx, j_nx;
  logic [IW-1:0] to_nx, na, nb;
  logic [PT_W-1:0] from_rd, to_rd;

  assign nf    = dir ? scnt : fcnt;
  assign nt    = dir ? fcnt : scnt;
  assign tn    = (fcnt < scnt) ? fcnt : scnt;
  assign i_nx  = i_idx + CW'(1);
  assign j_nx  = j_idx + CW'(1);
  assign to_nx = (j_nx == nt) ? '0 : j_nx[IW-1:0];
  assign na    = (i_nx == fcnt) ? '0 : i_nx[IW-1:0];
  assign nb    = (i_nx == scnt) ? '0 : i_nx[IW-1:0];
  assign from_rd = dir ? rd_s : rd_f;
  assign to_rd   = dir ? rd_f : rd_s;

  assign cmd_acc   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);
  assign wword     = {cmd.coord_x, cmd.coord_y, cmd.coord_z};
  assign we_f = cmd_acc && (cmd.action == ACT_LOAD_A) && (fcnt != FULL);
  assign we_s = cmd_acc && (cmd.action == ACT_LOAD_B) && (scnt != FULL);

  // Select read addresses
  always_comb begin
    raddr_f = '0;
    raddr_s = '0;
    case (state)
      S_H_RDP: begin
        raddr_f = dir ? '0 : i_idx[IW-1:0];
        raddr_s = dir ? i_idx[IW-1:0] : '0;
      end
      S_H_RDB: begin
        raddr_f = to_nx;
        raddr_s = to_nx;
      end
      S_T_RD0: begin
        raddr_f = i_idx[IW-1:0];
        raddr_s = i_idx[IW-1:0];
      end
      S_T_RD1: begin
        raddr_f = na;
        raddr_s = nb;
      end
      default: begin
        raddr_f = '0;
        raddr_s = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_f) mem_f[fcnt[IW-1:0]] <= wword;
    rd_f <= mem_f[raddr_f];
  end

  always_ff @(posedge clk) begin
    if (we_s) mem_s[scnt[IW-1:0]] <= wword;
    rd_s <= mem_s[raddr_s];
  end

  // Per-axis operands
  logic signed [DW-1:0] dv_k, av_k;
  logic [EW-1:0] dv_mag;
  assign dv_k   = dv[k];
  assign av_k   = av[k];
  assign dv_mag = mag(EW'(dv_k));

  // Projection parameter decision
  logic [AW-1:0] rr;
  assign rr = pos - neg;

  // Closest-point offset and residual
  logic [PRW-1:0] rnd;
  logic [DW-1:0]  mofs;
  logic signed [EW-1:0] offs, dd;
  assign rnd  = prod + HALF;
  assign mofs = DW'(rnd >> FRAC_BITS);
  assign offs = dv_k[DW-1] ? -$signed(EW'(mofs)) : $signed(EW'(mofs));
  assign dd   = EW'(av_k) - offs;

  // Tangent difference
  logic signed [TDW-1:0] ud;
  assign ud = TDW'(u0[k]) - TDW'(u1[k]);

  // Multiplier half product
  logic [MH-1:0]    mb_half;
  logic [MW+MH-1:0] pp;
  assign mb_half = mph ? mb[MW-1:MH] : mb[MH-1:0];
  assign pp      = ma * mb_half;

  // Divider step
  logic [DVW-1:0] dsh;
  logic           dge;
  assign dsh = (dcnt == '0) ? dv_rem : (dv_rem << 1);
  assign dge = (dsh >= dv_den);

  // Square root step
  logic [RTW+2:0] scur, strial;
  logic           sge;
  assign scur   = {srem, sq_rad[SQW-1 -: 2]};
  assign strial = (RTW+3)'({root, 2'b01});
  assign sge    = (scur >= strial);

  // Signed unit-tangent component from quotient
  logic signed [UW-1:0] uval;
  assign uval = dv_k[DW-1] ? -$signed(UW'(quo)) : $signed(UW'(quo));

  // Final tangent clamp and status
  logic [TW-1:0]     tc1;
  logic [TANG_W-1:0] te_out;
  logic [STAT_W-1:0] st_out;
  assign tc1    = (tworst > TCAP) ? TCAP : tworst;
  assign te_out = (tc1 > TW'(TANG_MAX)) ? TANG_MAX : tc1[TANG_W-1:0];
  assign st_out = few ? ST_FEW : (ovf ? ST_DROP : (hsat ? ST_SAT : ST_OK));

  assign rsp.valid      = o_valid;
  assign rsp.dist_bound = o_hb;
  assign rsp.tan_err    = o_te;
  assign rsp.status     = o_st;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fcnt    <= '0;
      scnt    <= '0;
      ovf     <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      // drop the result once taken
      if (o_valid && rsp.ready && state != S_FIN) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (cmd.action)
              ACT_CLEAR: begin
                fcnt <= '0;
                scnt <= '0;
                ovf  <= 1'b0;
              end
              ACT_LOAD_A: begin
                if (fcnt == FULL) ovf <= 1'b1;
                else fcnt <= fcnt + CW'(1);
              end
              ACT_LOAD_B: begin
                if (scnt == FULL) ovf <= 1'b1;
                else scnt <= scnt + CW'(1);
              end
              default: state <= S_START;
            endcase
          end
        end
        S_START: begin
          hsat   <= 1'b0;
          hb     <= '0;
          tworst <= '0;
          if (fcnt < CW'(2) || scnt < CW'(2)) begin
            few   <= 1'b1;
            state <= S_FIN;
          end else begin
            few   <= 1'b0;
            dir   <= 1'b0;
            i_idx <= '0;
            worst <= '0;
            state <= S_H_RDP;
          end
        end
        S_H_RDP: state <= S_H_CAP0;
        S_H_CAP0: begin
          p_pt  <= from_rd;
          a_pt  <= to_rd;
          z_pt  <= to_rd;
          j_idx <= '0;
          state <= S_H_RDB;
        end
        S_H_RDB: state <= S_H_CAPB;
        S_H_CAPB: begin
          b_pt  <= to_rd;
          state <= S_SEG0;
        end
        S_SEG0: begin
          for (int n = 0; n < 3; n++) begin
            dv[n] <= csub(coord(b_pt, 2'(n)), coord(a_pt, 2'(n)));
            av[n] <= csub(coord(p_pt, 2'(n)), coord(a_pt, 2'(n)));
          end
          ab2   <= '0;
          pos   <= '0;
          neg   <= '0;
          d2    <= '0;
          k     <= 2'd0;
          state <= S_SEG1;
        end
        S_SEG1: begin
          ma    <= MW'(dv_mag);
          mb    <= MW'(dv_mag);
          mph   <= 1'b0;
          ret   <= S_SEG2;
          state <= S_MUL;
        end
        S_SEG2: begin
          ab2   <= ab2 + prod;
          ma    <= MW'(dv_mag);
          mb    <= MW'(mag(EW'(av_k)));
          mph   <= 1'b0;
          ret   <= S_SEG3;
          state <= S_MUL;
        end
        S_SEG3: begin
          if (dv_k[DW-1] != av_k[DW-1]) neg <= neg + prod;
          else pos <= pos + prod;
          if (k == 2'd2) begin
            k     <= 2'd0;
            state <= S_SEG4;
          end else begin
            k     <= k + 2'd1;
            state <= S_SEG1;
          end
        end
        S_SEG4: begin
          // clamp the projection or divide for it
          if (ab2 != '0 && neg < pos) begin
            if (rr >= ab2) begin
              t     <= T_ONE;
              state <= S_SEG5;
            end else begin
              dv_rem <= rr;
              dv_den <= ab2;
              quo    <= '0;
              dcnt   <= '0;
              ret    <= S_SEG4B;
              state  <= S_DIV;
            end
          end else begin
            t     <= '0;
            state <= S_SEG5;
          end
        end
        S_SEG4B: begin
          t     <= quo;
          state <= S_SEG5;
        end
        S_SEG5: begin
          ma    <= MW'(dv_mag);
          mb    <= MW'(t);
          mph   <= 1'b0;
          ret   <= S_SEG6;
          state <= S_MUL;
        end
        S_SEG6: begin
          ma    <= MW'(mag(dd));
          mb    <= MW'(mag(dd));
          mph   <= 1'b0;
          ret   <= S_SEG7;
          state <= S_MUL;
        end
        S_SEG7: begin
          d2 <= d2 + prod;
          if (k == 2'd2) begin
            state <= S_SEG8;
          end else begin
            k     <= k + 2'd1;
            state <= S_SEG5;
          end
        end
        S_SEG8: begin
          if (j_idx == '0 || d2 < best) best <= d2;
          a_pt <= b_pt;
          if (j_nx == nt) begin
            state <= S_H_NEXT;
          end else begin
            j_idx <= j_nx;
            state <= S_H_RDB;
          end
        end
        S_H_NEXT: begin
          if (worst < best) worst <= best;
          if (i_nx == nf) begin
            i_idx <= '0;
            if (!dir) begin
              dir   <= 1'b1;
              state <= S_H_RDP;
            end else begin
              state <= S_H_SQ;
            end
          end else begin
            i_idx <= i_nx;
            state <= S_H_RDP;
          end
        end
        S_H_SQ: begin
          sq_rad <= SQW'(worst);
          srem   <= '0;
          root   <= '0;
          sq_cnt <= '0;
          ret    <= S_H_DONE;
          state  <= S_SQ;
        end
        S_H_DONE: begin
          hsat   <= |root[RTW-1:HB_W];
          hb     <= (|root[RTW-1:HB_W]) ? '1 : root[HB_W-1:0];
          i_idx  <= '0;
          tworst <= '0;
          state  <= S_T_RD0;
        end
        S_T_RD0: state <= S_T_CAP0;
        S_T_CAP0: begin
          a_pt  <= rd_f;
          p_pt  <= rd_s;
          state <= S_T_RD1;
        end
        S_T_RD1: state <= S_T_CAP1;
        S_T_CAP1: begin
          // first-set edge goes first, second-set edge end is kept in z_pt
          z_pt <= rd_s;
          for (int n = 0; n < 3; n++) begin
            dv[n] <= csub(coord(rd_f, 2'(n)), coord(a_pt, 2'(n)));
          end
          side  <= 1'b0;
          ab2   <= '0;
          k     <= 2'd0;
          state <= S_UE1;
        end
        S_UE1: begin
          ma    <= MW'(dv_mag);
          mb    <= MW'(dv_mag);
          mph   <= 1'b0;
          ret   <= S_UE2;
          state <= S_MUL;
        end
        S_UE2: begin
          ab2 <= ab2 + prod;
          if (k == 2'd2) begin
            state <= S_UE3;
          end else begin
            k     <= k + 2'd1;
            state <= S_UE1;
          end
        end
        S_UE3: begin
          if (ab2 == '0) begin
            for (int n = 0; n < 3; n++) begin
              if (side) u1[n] <= '0;
              else u0[n] <= '0;
            end
            state <= S_UE_END;
          end else begin
            sq_rad <= {ab2[N2W-1:0], {(2*FRAC_BITS){1'b0}}};
            srem   <= '0;
            root   <= '0;
            sq_cnt <= '0;
            ret    <= S_UE4;
            state  <= S_SQ;
          end
        end
        S_UE4: begin
          len   <= root;
          k     <= 2'd0;
          state <= S_UE5;
        end
        S_UE5: begin
          dv_rem <= DVW'(dv_mag) << FRAC_BITS;
          dv_den <= DVW'(len);
          quo    <= '0;
          dcnt   <= '0;
          ret    <= S_UE6;
          state  <= S_DIV;
        end
        S_UE6: begin
          if (side) u1[k] <= uval;
          else u0[k] <= uval;
          if (k == 2'd2) begin
            state <= S_UE_END;
          end else begin
            k     <= k + 2'd1;
            state <= S_UE5;
          end
        end
        S_UE_END: begin
          k <= 2'd0;
          if (!side) begin
            side <= 1'b1;
            for (int n = 0; n < 3; n++) begin
              dv[n] <= csub(coord(z_pt, 2'(n)), coord(p_pt, 2'(n)));
            end
            ab2   <= '0;
            state <= S_UE1;
          end else begin
            d2    <= '0;
            state <= S_T_D1;
          end
        end
        S_T_D1: begin
          ma    <= MW'(mag(EW'(ud)));
          mb    <= MW'(mag(EW'(ud)));
          mph   <= 1'b0;
          ret   <= S_T_D2;
          state <= S_MUL;
        end
        S_T_D2: begin
          d2 <= d2 + prod;
          if (k == 2'd2) begin
            state <= S_T_D3;
          end else begin
            k     <= k + 2'd1;
            state <= S_T_D1;
          end
        end
        S_T_D3: begin
          sq_rad <= SQW'(d2);
          srem   <= '0;
          root   <= '0;
          sq_cnt <= '0;
          ret    <= S_T_D4;
          state  <= S_SQ;
        end
        S_T_D4: begin
          if (root > RTW'(tworst)) tworst <= TW'(root);
          if (i_nx == tn) begin
            state <= S_FIN;
          end else begin
            i_idx <= i_nx;
            state <= S_T_RD0;
          end
        end
        S_MUL: begin
          // two half products, low then high
          if (mph) begin
            prod  <= prod + (PRW'(pp) << MH);
            mph   <= 1'b0;
            state <= ret;
          end else begin
            prod <= PRW'(pp);
            mph  <= 1'b1;
          end
        end
        S_DIV: begin
          dv_rem <= dge ? (dsh - dv_den) : dsh;
          quo    <= {quo[QW-2:0], dge};
          if (dcnt == DCW'(FRAC_BITS)) state <= ret;
          else dcnt <= dcnt + DCW'(1);
        end
        S_SQ: begin
          sq_rad <= sq_rad << 2;
          if (sge) begin
            srem <= (RTW+1)'(scur - strial);
            root <= {root[RTW-2:0], 1'b1};
          end else begin
            srem <= scur[RTW:0];
            root <= {root[RTW-2:0], 1'b0};
          end
          if (sq_cnt == SCW'(RTW - 1)) state <= ret;
          else sq_cnt <= sq_cnt + SCW'(1);
        end
        S_FIN: begin
          // hold until the output register is free
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_hb    <= hb;
            o_te    <= te_out;
            o_st    <= st_out;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/phte_checker.sv]
`timescale 1ns / 1ps

module phte_checker #(
  parameter int FRAC_BITS = phte_pkg::FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [phte_pkg::HB_W-1:0]   hb,
  input logic [phte_pkg::TANG_W-1:0] te,
  input logic [phte_pkg::STAT_W-1:0] st
);
  import phte_pkg::*;

  localparam logic [31:0] TCAP = 32'(1) << (FRAC_BITS + 1);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // too few points reports zero values
  a_few_zero: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && st == ST_FEW |-> hb == '0 && te == '0)
    else $error("short set with nonzero values");

  // saturation shows the maximum bound
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && st == ST_SAT |-> hb == '1)
    else $error("saturated status without maximum bound");

  // tangent error stays in range
  a_te_range: assert property (@(posedge clk) disable iff (rst)
      rsp_valid |-> 32'(te) <= TCAP)
    else $error("tangent error above cap");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hb) && $stable(te) && $stable(st))
    else $error("stalled result changed");

endmodule

bind polyline_hausdorff_tangent_error_unit phte_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .hb        (rsp.dist_bound),
  .te        (rsp.tan_err),
  .st        (rsp.status)
);
